### src/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg: shared types and constants for the page frame replacement table
// Policy codes, scan flag bundle and fixed field widths.
// ----------------------------------------------------------------------------
package pfr_pkg;

    typedef logic [1:0] policy_t;

    localparam policy_t POL_FIFO = 2'd0;
    localparam policy_t POL_LRU  = 2'd1;
    localparam policy_t POL_LFU  = 2'd2;

    localparam int FAULT_BITS = 32;
    localparam int SLOT_BITS  = 2;

    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    // findings collected by the scan unit over one pass
    typedef struct packed {
        logic hit_found;
        logic empty_found;
        logic fifo_valid;
    } pfr_flags_t;

endpackage

### src/page_frame_replacement.sv
// ----------------------------------------------------------------------------
// page_frame_replacement: fully associative frame table, FIFO/LRU/LFU
// Looks up a page, picks a victim on a fault, reports eviction and faults.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   ------------------------------------------
//  command   start / busy         action, page_number
//  result    done (one cycle)     hit, frame_slot, evicted_valid,
//                                 evicted_page, fault_total
//  config    cfg_write            cfg_data (replacement policy)
//
// An access word passes from the accepting edge through the scan of every
// frame in the shared compare unit (one frame per cycle), then the update
// state, and ends with the done pulse that carries its result.
// A flush skips the scan and goes straight to update, then done.
// busy is high from the accepting edge until the result is registered; done
// pulses in the following cycle, which already accepts the next word.
// Reset empties all frames, clears scores, pointer, fault count and policy.
// The receiver cannot stall: done lasts one cycle and is not held.
//
module page_frame_replacement #(
    parameter int FRAME_COUNT = 3,
    parameter int PAGE_BITS   = 16,
    parameter int SCORE_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            action,
    input  logic [PAGE_BITS-1:0]            page_number,
    input  logic                            cfg_write,
    input  pfr_pkg::policy_t                cfg_data,
    output logic                            done,
    output logic                            hit,
    output logic [pfr_pkg::SLOT_BITS-1:0]   frame_slot,
    output logic                            evicted_valid,
    output logic [PAGE_BITS-1:0]            evicted_page,
    output logic [pfr_pkg::FAULT_BITS-1:0]  fault_total
);

    localparam int IDX_W  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int WIDE_W = IDX_W + pfr_pkg::SLOT_BITS;
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(FRAME_COUNT - 1);
    localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;
    localparam logic [SCORE_BITS-1:0] SCORE_ONE = SCORE_BITS'(1);
    localparam logic [pfr_pkg::FAULT_BITS-1:0] FAULT_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_UPDATE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // frame table
    logic [PAGE_BITS-1:0]  page_reg  [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] valid_reg;
    logic [SCORE_BITS-1:0] score_reg [FRAME_COUNT];
    logic [IDX_W-1:0]      ptr_reg;
    logic [pfr_pkg::FAULT_BITS-1:0] fault_reg;
    pfr_pkg::policy_t      policy_reg;

    // latched command word and scan index
    logic                  action_reg;
    logic [PAGE_BITS-1:0]  key_reg;
    logic [IDX_W-1:0]      idx_reg;

    // registered result
    logic                  done_reg, hit_reg, ev_valid_reg;
    logic [pfr_pkg::SLOT_BITS-1:0] slot_out_reg;
    logic [PAGE_BITS-1:0]  ev_page_reg;

    // scan unit findings
    pfr_pkg::pfr_flags_t   flags;
    logic [IDX_W-1:0]      hit_idx, empty_idx, best_idx;
    logic [SCORE_BITS-1:0] hit_score;
    logic [PAGE_BITS-1:0]  best_page, fifo_page;

    logic                  scanning, accept, scored, is_lru, is_lfu;
    logic [SCORE_BITS-1:0] age_inc, hit_inc;
    logic [IDX_W-1:0]      slot;
    logic [WIDE_W-1:0]     slot_wide;
    logic                  ev_valid;
    logic [PAGE_BITS-1:0]  ev_page;

    assign accept   = start && !busy;
    assign scanning = (state_reg == S_SCAN);
    assign is_lru   = (policy_reg == pfr_pkg::POL_LRU);
    assign is_lfu   = (policy_reg == pfr_pkg::POL_LFU);
    assign scored   = is_lru || is_lfu;

    pfr_scan #(
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_BITS   (PAGE_BITS),
        .SCORE_BITS  (SCORE_BITS),
        .IDX_W       (IDX_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (scanning),
        .first     (idx_reg == '0),
        .idx       (idx_reg),
        .fifo_ptr  (ptr_reg),
        .policy    (policy_reg),
        .key       (key_reg),
        .frm_valid (valid_reg[idx_reg]),
        .frm_page  (page_reg[idx_reg]),
        .frm_score (score_reg[idx_reg]),
        .flags     (flags),
        .hit_idx   (hit_idx),
        .hit_score (hit_score),
        .empty_idx (empty_idx),
        .best_idx  (best_idx),
        .best_page (best_page),
        .fifo_page (fifo_page)
    );

    // saturating increments: LRU ageing of the scanned frame, LFU hit count
    assign age_inc = (score_reg[idx_reg] == SCORE_MAX) ? SCORE_MAX
                                                       : score_reg[idx_reg] + SCORE_ONE;
    assign hit_inc = (hit_score == SCORE_MAX) ? SCORE_MAX : hit_score + SCORE_ONE;

    // victim choice after the scan
    always_comb
    begin
        ev_valid = 1'b0;
        ev_page  = '0;
        if (flags.hit_found)
            slot = hit_idx;
        else if (scored)
        begin
            if (flags.empty_found)
                slot = empty_idx;
            else
            begin
                slot     = best_idx;
                ev_valid = 1'b1;
                ev_page  = best_page;
            end
        end
        else
        begin
            // FIFO, also for the unused policy code
            slot     = ptr_reg;
            ev_valid = flags.fifo_valid;
            ev_page  = flags.fifo_valid ? fifo_page : '0;
        end
        slot_wide = WIDE_W'(slot);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = (action == pfr_pkg::ACT_FLUSH) ? S_UPDATE : S_SCAN;
            S_SCAN:
                if (idx_reg == LAST_IDX)
                    state_next = S_UPDATE;
            S_UPDATE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            valid_reg  <= '0;
            ptr_reg    <= '0;
            fault_reg  <= '0;
            policy_reg <= pfr_pkg::POL_FIFO;
            done_reg   <= 1'b0;
            for (int i = 0; i < FRAME_COUNT; i++)
                score_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_UPDATE);
            if (cfg_write)
                policy_reg <= cfg_data;
            if (accept)
                idx_reg <= '0;
            else if (scanning && idx_reg != LAST_IDX)
                idx_reg <= idx_reg + 1'b1;

            // LRU: age each valid frame as the scan passes it
            if (scanning && is_lru && valid_reg[idx_reg])
                score_reg[idx_reg] <= age_inc;

            if (state_reg == S_UPDATE)
            begin
                if (action_reg == pfr_pkg::ACT_FLUSH)
                begin
                    valid_reg <= '0;
                    ptr_reg   <= '0;
                    fault_reg <= '0;
                    for (int i = 0; i < FRAME_COUNT; i++)
                        score_reg[i] <= '0;
                end
                else
                begin
                    if (!flags.hit_found)
                    begin
                        valid_reg[slot] <= 1'b1;
                        if (fault_reg != FAULT_MAX)
                            fault_reg <= fault_reg + 1'b1;
                        if (!scored)
                            ptr_reg <= (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
                    end
                    if (is_lru)
                        score_reg[slot] <= '0;
                    else if (is_lfu)
                        score_reg[slot] <= flags.hit_found ? hit_inc : SCORE_ONE;
                end
            end
        end
    end

    // payload: command latch, page write, result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            key_reg    <= page_number;
        end
        if (state_reg == S_UPDATE)
        begin
            if (action_reg == pfr_pkg::ACT_FLUSH)
            begin
                hit_reg      <= 1'b0;
                slot_out_reg <= '0;
                ev_valid_reg <= 1'b0;
                ev_page_reg  <= '0;
            end
            else
            begin
                if (!flags.hit_found)
                    page_reg[slot] <= key_reg;
                hit_reg      <= flags.hit_found;
                slot_out_reg <= slot_wide[pfr_pkg::SLOT_BITS-1:0];
                ev_valid_reg <= ev_valid && !flags.hit_found;
                ev_page_reg  <= flags.hit_found ? '0 : ev_page;
            end
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign frame_slot    = slot_out_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_total   = fault_reg;

endmodule

### src/pfr_scan.sv
// ----------------------------------------------------------------------------
// pfr_scan: shared compare unit for the frame scan
// One frame per cycle: match, first empty, best score and FIFO victim capture.
// ----------------------------------------------------------------------------
module pfr_scan #(
    parameter int FRAME_COUNT = 3,
    parameter int PAGE_BITS   = 16,
    parameter int SCORE_BITS  = 16,
    parameter int IDX_W       = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  first,
    input  logic [IDX_W-1:0]      idx,
    input  logic [IDX_W-1:0]      fifo_ptr,
    input  pfr_pkg::policy_t      policy,
    input  logic [PAGE_BITS-1:0]  key,
    input  logic                  frm_valid,
    input  logic [PAGE_BITS-1:0]  frm_page,
    input  logic [SCORE_BITS-1:0] frm_score,
    output pfr_pkg::pfr_flags_t   flags,
    output logic [IDX_W-1:0]      hit_idx,
    output logic [SCORE_BITS-1:0] hit_score,
    output logic [IDX_W-1:0]      empty_idx,
    output logic [IDX_W-1:0]      best_idx,
    output logic [PAGE_BITS-1:0]  best_page,
    output logic [PAGE_BITS-1:0]  fifo_page
);

    pfr_pkg::pfr_flags_t   flags_reg, flags_next;
    logic [IDX_W-1:0]      hit_idx_reg, empty_idx_reg, best_idx_reg;
    logic [SCORE_BITS-1:0] hit_score_reg, best_score_reg;
    logic [PAGE_BITS-1:0]  best_page_reg, fifo_page_reg;
    logic                  prev_hit, prev_empty;
    logic                  take_hit, take_empty, take_best, take_fifo;

    always_comb
    begin
        prev_hit   = first ? 1'b0 : flags_reg.hit_found;
        prev_empty = first ? 1'b0 : flags_reg.empty_found;
        take_hit   = !prev_hit && frm_valid && (frm_page == key);
        take_empty = !prev_empty && !frm_valid;
        // LRU keeps the largest age, LFU the smallest count; ties keep the lower index
        if (first)
            take_best = 1'b1;
        else if (policy == pfr_pkg::POL_LRU)
            take_best = frm_score > best_score_reg;
        else
            take_best = frm_score < best_score_reg;
        take_fifo = (idx == fifo_ptr);

        flags_next             = flags_reg;
        flags_next.hit_found   = prev_hit | take_hit;
        flags_next.empty_found = prev_empty | take_empty;
        if (take_fifo)
            flags_next.fifo_valid = frm_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= '0;
        else if (step)
            flags_reg <= flags_next;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (take_hit)
            begin
                hit_idx_reg   <= idx;
                hit_score_reg <= frm_score;
            end
            if (take_empty)
                empty_idx_reg <= idx;
            if (take_best)
            begin
                best_idx_reg   <= idx;
                best_score_reg <= frm_score;
                best_page_reg  <= frm_page;
            end
            if (take_fifo)
                fifo_page_reg <= frm_page;
        end
    end

    assign flags     = flags_reg;
    assign hit_idx   = hit_idx_reg;
    assign hit_score = hit_score_reg;
    assign empty_idx = empty_idx_reg;
    assign best_idx  = best_idx_reg;
    assign best_page = best_page_reg;
    assign fifo_page = fifo_page_reg;

endmodule

### tb/page_frame_replacement_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_frame_replacement_test: self-checking bench for the frame table
// Drives access and flush words under every policy code and compares each
// result word with a cycle-free model of the table kept in the bench.
// ----------------------------------------------------------------------------
module page_frame_replacement_test;

    localparam int FRAMES      = 3;
    localparam int PAGE_BITS   = 16;
    localparam int SCORE_BITS  = 16;
    localparam int STALL_LIMIT = 500;  // cycles with no handshake at all
    localparam int DRAIN_WAIT  = 20;   // tail after the last result word
    localparam int RAND_PHASES = 12;
    localparam int PHASE_WORDS = 95;
    localparam int MAX_REPORTS = 40;

    // code 3 has no name in the package; the table treats it as FIFO
    localparam pfr_pkg::policy_t POL_SPARE = 2'd3;

    // one result word as the table reports it
    typedef struct packed {
        logic                           hit;
        logic [pfr_pkg::SLOT_BITS-1:0]  frame_slot;
        logic                           evicted_valid;
        logic [PAGE_BITS-1:0]           evicted_page;
        logic [pfr_pkg::FAULT_BITS-1:0] fault_total;
    } lookup_word_t;

    // ------------------------------------------------------------------
    // clock, reset, block ports
    // ------------------------------------------------------------------
    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           start         = 1'b0;
    logic                           action        = pfr_pkg::ACT_ACCESS;
    logic [PAGE_BITS-1:0]           page_number   = '0;
    logic                           cfg_write     = 1'b0;
    pfr_pkg::policy_t               cfg_data      = pfr_pkg::POL_FIFO;
    logic                           busy;
    logic                           done;
    logic                           hit;
    logic [pfr_pkg::SLOT_BITS-1:0]  frame_slot;
    logic                           evicted_valid;
    logic [PAGE_BITS-1:0]           evicted_page;
    logic [pfr_pkg::FAULT_BITS-1:0] fault_total;

    always #5 clk = ~clk;

    page_frame_replacement #(
        .FRAME_COUNT (FRAMES),
        .PAGE_BITS   (PAGE_BITS),
        .SCORE_BITS  (SCORE_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .page_number   (page_number),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .done          (done),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

    // ------------------------------------------------------------------
    // shadow copy of the frame table
    // ------------------------------------------------------------------
    logic [PAGE_BITS-1:0]           resident_page  [FRAMES];
    logic                           resident_valid [FRAMES];
    logic [SCORE_BITS-1:0]          frame_age_use  [FRAMES];  // LRU age or LFU use count
    int                             fifo_next;
    logic [pfr_pkg::FAULT_BITS-1:0] faults_so_far;
    pfr_pkg::policy_t               active_policy;

    // result words still owed by the table, oldest first
    lookup_word_t          pending_lookups[$];
    lookup_word_t          oldest_lookup;

    int error_count    = 0;
    int words_sent     = 0;
    int flushes_sent   = 0;
    int hits_seen      = 0;
    int evictions_seen = 0;
    int policy_writes  = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;

    // Work out the result of one word and advance the shadow table.
    function automatic lookup_word_t model_lookup(input logic act,
                                                  input logic [PAGE_BITS-1:0] pg);
        lookup_word_t res;
        int           slot;
        logic         found;
        logic         empty_found;

        res   = '0;
        slot  = 0;
        found = 1'b0;

        if (act == pfr_pkg::ACT_FLUSH)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                resident_page[i]  = '0;
                resident_valid[i] = 1'b0;
                frame_age_use[i]  = '0;
            end
            fifo_next     = 0;
            faults_so_far = '0;
            return res;
        end

        // lowest matching frame wins
        for (int i = 0; i < FRAMES; i++)
        begin
            if (!found && resident_valid[i] && resident_page[i] == pg)
            begin
                slot  = i;
                found = 1'b1;
            end
        end

        if (!found)
        begin
            if (active_policy == pfr_pkg::POL_LRU || active_policy == pfr_pkg::POL_LFU)
            begin
                empty_found = 1'b0;
                for (int i = 0; i < FRAMES; i++)
                begin
                    if (!empty_found && !resident_valid[i])
                    begin
                        slot        = i;
                        empty_found = 1'b1;
                    end
                end
                if (!empty_found)
                begin
                    slot = 0;
                    for (int i = 1; i < FRAMES; i++)
                    begin
                        if (active_policy == pfr_pkg::POL_LRU)
                        begin
                            if (frame_age_use[i] > frame_age_use[slot])
                                slot = i;
                        end
                        else if (frame_age_use[i] < frame_age_use[slot])
                        begin
                            slot = i;
                        end
                    end
                end
            end
            else
            begin
                // FIFO and the spare code: round-robin pointer
                slot      = fifo_next % FRAMES;
                fifo_next = (slot + 1) % FRAMES;
            end
            if (resident_valid[slot])
            begin
                res.evicted_valid = 1'b1;
                res.evicted_page  = resident_page[slot];
            end
            resident_page[slot]  = pg;
            resident_valid[slot] = 1'b1;
            if (faults_so_far != '1)
                faults_so_far++;
            if (active_policy == pfr_pkg::POL_LFU)
                frame_age_use[slot] = 1;
        end
        else if (active_policy == pfr_pkg::POL_LFU)
        begin
            if (frame_age_use[slot] != '1)
                frame_age_use[slot]++;
        end

        if (active_policy == pfr_pkg::POL_LRU)
        begin
            for (int i = 0; i < FRAMES; i++)
                if (resident_valid[i] && frame_age_use[i] != '1)
                    frame_age_use[i]++;
            frame_age_use[slot] = '0;
        end

        res.hit         = found;
        res.frame_slot  = slot[pfr_pkg::SLOT_BITS-1:0];
        res.fault_total = faults_so_far;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // result checker: the receiver never stalls, so every done is taken
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_lookups.size() == 0)
            begin
                error_count++;
                $display("%0t: result word with nothing pending, expected none, got hit=%0b",
                         $time, hit);
            end
            else
            begin
                oldest_lookup = pending_lookups.pop_front();
                check_field("hit",           oldest_lookup.hit,           hit);
                check_field("frame_slot",    oldest_lookup.frame_slot,    frame_slot);
                check_field("evicted_valid", oldest_lookup.evicted_valid, evicted_valid);
                check_field("evicted_page",  oldest_lookup.evicted_page,  evicted_page);
                check_field("fault_total",   oldest_lookup.fault_total,   fault_total);
                if (hit)
                    hits_seen++;
                if (evicted_valid)
                    evictions_seen++;
            end
        end
    end

    // watchdog: any accepted word or result word restarts the count
    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_lookups.size());
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // Offer one word, wait for the accepting edge, then maybe take a gap.
    // start stays high between words of a burst.
    task automatic send_word(input logic act, input logic [PAGE_BITS-1:0] pg);
        start       <= 1'b1;
        action      <= act;
        page_number <= pg;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_lookups.push_back(model_lookup(act, pg));
        words_sent++;
        if (act == pfr_pkg::ACT_FLUSH)
            flushes_sent++;

        // bursts of random length, gaps drawn at random so that they land
        // on every phase of the scan; now and then a long gap-free run
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Stop offering words and wait until every owed result has arrived.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    // Policy changes only while the table is idle.
    task automatic write_policy(input pfr_pkg::policy_t pol);
        drain_results();
        cfg_write <= 1'b1;
        cfg_data  <= pol;
        @(posedge clk);
        cfg_write     <= 1'b0;
        active_policy  = pol;
        policy_writes++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extreme page numbers, a hit, then round-robin eviction
    task automatic test_fifo_eviction();
        write_policy(pfr_pkg::POL_FIFO);
        send_word(pfr_pkg::ACT_ACCESS, 16'h0000);
        send_word(pfr_pkg::ACT_ACCESS, 16'hFFFF);
        send_word(pfr_pkg::ACT_ACCESS, 16'h0000);   // hit on frame 0
        send_word(pfr_pkg::ACT_ACCESS, 16'h8001);
        send_word(pfr_pkg::ACT_ACCESS, 16'h1234);   // evicts 0x0000
        send_word(pfr_pkg::ACT_FLUSH,  16'hFFFF);   // page ignored on flush
    endtask

    // empty frames first, then the oldest frame goes
    task automatic test_lru_eviction();
        write_policy(pfr_pkg::POL_LRU);
        send_word(pfr_pkg::ACT_ACCESS, 16'h0001);
        send_word(pfr_pkg::ACT_ACCESS, 16'h0002);
        send_word(pfr_pkg::ACT_ACCESS, 16'h0003);
        send_word(pfr_pkg::ACT_ACCESS, 16'h0001);   // hit, 0x0002 is now oldest
        send_word(pfr_pkg::ACT_ACCESS, 16'h0004);   // evicts 0x0002
        send_word(pfr_pkg::ACT_FLUSH,  16'h0000);
    endtask

    // least used frame goes, lowest index on a tie; new pages start at one
    task automatic test_lfu_eviction();
        write_policy(pfr_pkg::POL_LFU);
        send_word(pfr_pkg::ACT_ACCESS, 16'hA000);
        send_word(pfr_pkg::ACT_ACCESS, 16'hB000);
        send_word(pfr_pkg::ACT_ACCESS, 16'hC000);
        send_word(pfr_pkg::ACT_ACCESS, 16'hA000);
        send_word(pfr_pkg::ACT_ACCESS, 16'hB000);
        send_word(pfr_pkg::ACT_ACCESS, 16'h7FFF);   // evicts 0xC000
        send_word(pfr_pkg::ACT_ACCESS, 16'h5555);   // evicts 0x7FFF, the newcomer
    endtask

    // spare code acts as FIFO and inherits the LFU contents and pointer
    task automatic test_unused_policy_code();
        write_policy(POL_SPARE);
        send_word(pfr_pkg::ACT_ACCESS, 16'hAAAA);
        send_word(pfr_pkg::ACT_ACCESS, 16'h5555);   // hit
        send_word(pfr_pkg::ACT_ACCESS, 16'h0F0F);
        send_word(pfr_pkg::ACT_FLUSH,  16'h1234);
    endtask

    // Phases of mixed traffic drawn mostly from a small page pool so that
    // hits and evictions are common; the policy is rewritten on every phase and
    // often without a flush, so scores and pointer carry over.
    task automatic test_random_traffic();
        logic [PAGE_BITS-1:0] page_pool[6];
        int                   pool_size;
        logic                 act;
        logic [PAGE_BITS-1:0] pg;

        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            if (phase < 4)
                write_policy(pfr_pkg::policy_t'(phase));
            else
                write_policy(pfr_pkg::policy_t'($urandom_range(0, 3)));
            if ($urandom_range(0, 1) == 0)
                send_word(pfr_pkg::ACT_FLUSH, PAGE_BITS'($urandom));

            pool_size = $urandom_range(3, 6);
            for (int i = 0; i < 6; i++)
                page_pool[i] = PAGE_BITS'($urandom);
            page_pool[0] = (phase % 2 == 0) ? 16'h0000 : 16'hFFFF;

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                act = ($urandom_range(0, 29) == 0) ? pfr_pkg::ACT_FLUSH
                                                   : pfr_pkg::ACT_ACCESS;
                if ($urandom_range(0, 7) == 0)
                    pg = PAGE_BITS'($urandom);
                else
                    pg = page_pool[$urandom_range(0, pool_size - 1)];
                send_word(act, pg);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            resident_page[i]  = '0;
            resident_valid[i] = 1'b0;
            frame_age_use[i]  = '0;
        end
        fifo_next     = 0;
        faults_so_far = '0;
        active_policy = pfr_pkg::POL_FIFO;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fifo_eviction();
        test_lru_eviction();
        test_lfu_eviction();
        test_unused_policy_code();
        test_random_traffic();

        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d words (%0d flushes) over %0d policy writes, all four codes",
                 words_sent, flushes_sent, policy_writes);
        $display("table reported %0d hits and %0d evictions, %0d mismatches",
                 hits_seen, evictions_seen, error_count);
        if (error_count == 0 && pending_lookups.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### page_frame_replacement.f
src/pfr_pkg.sv
src/pfr_scan.sv
src/page_frame_replacement.sv
tb/page_frame_replacement_test.sv
